// ----- rtl/core/crw_pkg.sv -----
package crw_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Width of the entry count as it leaves the block.
    localparam int COUNT_OUT_W = 7;

    // Operation codes carried on the operation port.
    localparam logic [1:0] OP_LOOKUP   = 2'd0;
    localparam logic [1:0] OP_REMEMBER = 2'd1;
    localparam logic [1:0] OP_EXPIRE   = 2'd2;

    // One stored command identity with its execute tick.
    typedef struct packed {
        logic [7:0]  kind;
        logic [31:0] source;
        logic [63:0] command;
        logic [63:0] tick;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/core/crw_ram.sv -----
module crw_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wen,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              ren,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/command_replay_window.sv -----
// Command replay window: a table of up to TABLE_DEPTH command identities used
// to spot duplicated commands.
// A word is accepted on the command channel at a rising edge where start is
// high and busy is low. The operation port selects a lookup, a remember or an
// expire; the other fields of the word are used as that operation needs.
// Each word yields exactly one result word, shown on found, done_res, healthy
// and entry_count for a single cycle while valid is high. The receiver cannot
// stall, so the result must be taken in that cycle.
// A remember, a refused expire and an unknown operation finish at once: the
// result appears the cycle after acceptance and the next word may follow
// straight away. A lookup or an accepted expire walks the stored entries
// through the single read port of the entry memory, one entry a cycle, and
// hands out its result when the walk ends; a lookup stops early at the first
// match.
// An expire compacts the table in place: kept entries are written back at
// the lower kept index while the read pointer runs ahead of it.
// Reset empties the table (fill count zero) and sets the healthy flag. The
// entry memory itself is not cleared; only entries below the fill count are
// ever read.
module command_replay_window (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          operation,
    input  logic [7:0]                          source_kind,
    input  logic [31:0]                         source_number,
    input  logic [63:0]                         command_number,
    input  logic [63:0]                         execute_tick,
    input  logic [63:0]                         retain_floor,
    input  logic [63:0]                         current_tick,
    input  logic                                world_open,
    output logic                                valid,
    output logic                                found,
    output logic                                done_res,
    output logic                                healthy,
    output logic [crw_pkg::COUNT_OUT_W-1:0]     entry_count
);

    // Sequencer states: idle waits for a word, scan walks the table.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg;
    logic state_next;

    // Table bookkeeping.
    logic [crw_pkg::CNT_W-1:0] fill_reg;
    logic [crw_pkg::CNT_W-1:0] fill_next;
    logic                      healthy_reg;
    logic                      healthy_next;

    // Fields of the word under work, held for the length of a scan.
    logic [1:0]  op_reg;
    logic [1:0]  op_next;
    logic [7:0]  kind_reg;
    logic [7:0]  kind_next;
    logic [31:0] src_reg;
    logic [31:0] src_next;
    logic [63:0] cmd_reg;
    logic [63:0] cmd_next;
    logic [63:0] floor_reg;
    logic [63:0] floor_next;

    // Scan pointers. The read pointer runs one entry ahead of the compare.
    logic [crw_pkg::CNT_W-1:0] rd_ptr_reg;
    logic [crw_pkg::CNT_W-1:0] rd_ptr_next;
    logic [crw_pkg::CNT_W-1:0] kept_reg;
    logic [crw_pkg::CNT_W-1:0] kept_next;
    logic                      cmp_valid_reg;
    logic                      cmp_valid_next;
    logic                      cmp_last_reg;
    logic                      cmp_last_next;

    // Result registers.
    logic                            valid_reg;
    logic                            found_reg;
    logic                            done_reg;
    logic                            healthy_out_reg;
    logic [crw_pkg::COUNT_OUT_W-1:0] count_out_reg;

    logic res_fire;
    logic res_found;
    logic res_done;

    // Entry memory ports.
    logic                        ram_wen;
    logic [crw_pkg::IDX_W-1:0]   ram_waddr;
    crw_pkg::entry_t             ram_wdata;
    logic                        ram_ren;
    logic [crw_pkg::IDX_W-1:0]   ram_raddr;
    logic [crw_pkg::ENTRY_W-1:0] ram_rdata_bits;
    crw_pkg::entry_t             ram_rdata;

    crw_pkg::entry_t new_entry;
    logic            table_full;
    logic            expire_refused;
    logic            floor_one_past;
    logic            match_hit;
    logic            keep_hit;

    crw_ram #(
        .DATA_W (crw_pkg::ENTRY_W),
        .DEPTH  (crw_pkg::TABLE_DEPTH),
        .ADDR_W (crw_pkg::IDX_W)
    ) u_entry_ram (
        .clk   (clk),
        .wen   (ram_wen),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .ren   (ram_ren),
        .raddr (ram_raddr),
        .rdata (ram_rdata_bits)
    );

    assign ram_rdata = crw_pkg::entry_t'(ram_rdata_bits);

    assign new_entry.kind    = source_kind;
    assign new_entry.source  = source_number;
    assign new_entry.command = command_number;
    assign new_entry.tick    = execute_tick;

    assign table_full = (fill_reg == crw_pkg::CNT_W'(crw_pkg::TABLE_DEPTH));

    // A floor exactly one past the current tick is still allowed, unless the
    // current tick is already at its largest value.
    assign floor_one_past = (current_tick != '1) && (retain_floor == current_tick + 64'd1);
    assign expire_refused = !world_open || (retain_floor == 64'd0) ||
                            ((retain_floor > current_tick) && !floor_one_past);

    // Compare stage, working on the entry read in the previous cycle.
    assign match_hit = cmp_valid_reg && (op_reg == crw_pkg::OP_LOOKUP) &&
                       (ram_rdata.kind == kind_reg) && (ram_rdata.source == src_reg) &&
                       (ram_rdata.command == cmd_reg);
    assign keep_hit  = cmp_valid_reg && (op_reg == crw_pkg::OP_EXPIRE) &&
                       (ram_rdata.tick >= floor_reg);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        healthy_next   = healthy_reg;
        op_next        = op_reg;
        kind_next      = kind_reg;
        src_next       = src_reg;
        cmd_next       = cmd_reg;
        floor_next     = floor_reg;
        rd_ptr_next    = rd_ptr_reg;
        kept_next      = kept_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_last_next  = cmp_last_reg;
        res_fire       = 1'b0;
        res_found      = 1'b0;
        res_done       = 1'b0;
        ram_wen        = 1'b0;
        ram_waddr      = kept_reg[crw_pkg::IDX_W-1:0];
        ram_wdata      = ram_rdata;
        ram_ren        = 1'b0;
        ram_raddr      = rd_ptr_reg[crw_pkg::IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next        = operation;
                    kind_next      = source_kind;
                    src_next       = source_number;
                    cmd_next       = command_number;
                    floor_next     = retain_floor;
                    rd_ptr_next    = '0;
                    kept_next      = '0;
                    cmp_valid_next = 1'b0;
                    cmp_last_next  = 1'b0;

                    unique case (operation)
                        crw_pkg::OP_LOOKUP:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_fire = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        crw_pkg::OP_REMEMBER:
                        begin
                            res_fire = 1'b1;
                            if (table_full)
                            begin
                                healthy_next = 1'b0;
                            end
                            else
                            begin
                                ram_wen   = 1'b1;
                                ram_waddr = fill_reg[crw_pkg::IDX_W-1:0];
                                ram_wdata = new_entry;
                                fill_next = fill_reg + crw_pkg::CNT_W'(1);
                                res_done  = 1'b1;
                            end
                        end
                        crw_pkg::OP_EXPIRE:
                        begin
                            if (expire_refused)
                            begin
                                res_fire = 1'b1;
                            end
                            else if (fill_reg == '0)
                            begin
                                res_fire = 1'b1;
                                res_done = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            res_fire = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (keep_hit)
                begin
                    ram_wen   = 1'b1;
                    ram_waddr = kept_reg[crw_pkg::IDX_W-1:0];
                    ram_wdata = ram_rdata;
                    kept_next = kept_reg + crw_pkg::CNT_W'(1);
                end

                if (match_hit || (cmp_valid_reg && cmp_last_reg))
                begin
                    state_next     = ST_IDLE;
                    cmp_valid_next = 1'b0;
                    res_fire       = 1'b1;
                    res_found      = match_hit;
                    if (op_reg == crw_pkg::OP_EXPIRE)
                    begin
                        res_done  = 1'b1;
                        fill_next = kept_next;
                    end
                end
                else if (rd_ptr_reg != fill_reg)
                begin
                    ram_ren        = 1'b1;
                    rd_ptr_next    = rd_ptr_reg + crw_pkg::CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_last_next  = (rd_ptr_reg == fill_reg - crw_pkg::CNT_W'(1));
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            healthy_reg   <= 1'b1;
            rd_ptr_reg    <= '0;
            kept_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            healthy_reg   <= healthy_next;
            rd_ptr_reg    <= rd_ptr_next;
            kept_reg      <= kept_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_last_reg  <= cmp_last_next;
            valid_reg     <= res_fire;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        kind_reg  <= kind_next;
        src_reg   <= src_next;
        cmd_reg   <= cmd_next;
        floor_reg <= floor_next;
        if (res_fire)
        begin
            found_reg       <= res_found;
            done_reg        <= res_done;
            healthy_out_reg <= healthy_next;
            count_out_reg   <= crw_pkg::COUNT_OUT_W'(fill_next);
        end
    end

    assign busy        = (state_reg == ST_SCAN);
    assign valid       = valid_reg;
    assign found       = found_reg;
    assign done_res    = done_reg;
    assign healthy     = healthy_out_reg;
    assign entry_count = count_out_reg;

`ifndef SYNTHESIS
    // Compaction must never overwrite an entry that has not yet been read.
    a_write_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wen && ram_ren && busy) |-> (ram_waddr < ram_raddr))
        else $error("compaction write overtook the read pointer");

    // The end of a scan always hands out its result in the same cycle.
    a_scan_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> valid)
        else $error("scan finished without a result");

    // The table never holds more than its depth.
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= crw_pkg::CNT_W'(crw_pkg::TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // Once lost, health is never regained short of a reset.
    a_healthy_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !healthy_reg |=> !healthy_reg)
        else $error("healthy flag set again without reset");
`endif

endmodule
